### rtl/core/eaap_pkg.sv
package eaap_pkg;

    localparam int unsigned ACC_W     = 15;
    localparam int unsigned WRAP_W    = 8;
    localparam int unsigned SAMP_W    = 24;
    localparam int unsigned AVG_W     = 32;
    localparam int unsigned ENERGY_W  = 26;

    // An uncompensated energy reading is at most 256 * 32767, which fits 23 bits.
    localparam int unsigned PLAIN_W   = WRAP_W + ACC_W;
    // A compensated energy also carries up to 255 extra wraps of 32768.
    localparam int unsigned COMP_W    = PLAIN_W + 1;

    localparam int unsigned CNT_W     = $clog2(AVG_W);

    localparam int unsigned QDEPTH_DEFAULT = 2;

    typedef struct packed {
        logic [ACC_W-1:0]  accum_value;
        logic [WRAP_W-1:0] wrap_count;
        logic [SAMP_W-1:0] samples_total;
    } t_reading;

    typedef struct packed {
        logic [AVG_W-1:0]    avg_power;
        logic [ENERGY_W-1:0] energy_now;
        logic                zero_samples;
    } t_result;

    // One classified word, ready for the divider.
    typedef struct packed {
        logic [AVG_W-1:0]    dividend;
        logic [SAMP_W-1:0]   divisor;
        logic [ENERGY_W-1:0] energy_now;
        logic                zero_samples;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_DIV,
        BS_HOLD
    } t_bstate;

endpackage

### rtl/core/energy_accumulator_average_power.sv
// Average power from successive energy readings.
//
// Input channel: a reading word (accumulator, rollover count, sample count)
// is taken on a rising edge with push high and full low. The front end turns
// it at once into an energy value, the energy difference and the sample
// difference against the previous reading, and places that word in a short
// queue (QUEUE_DEPTH words). Full is the queue being full.
// Result channel: while empty is low the oldest result word is on o_result;
// it is taken on a rising edge with pop high and empty low.
// Back end: a radix-2 restoring divider that produces one quotient bit per
// cycle. A word is loaded, divided one quotient bit per step from the most
// significant down, and then shown; a zero sample difference skips the
// divider. The back end takes the next word from the queue only after the
// previous result has been popped.
// A stalled receiver holds the result in the output register; the front end
// keeps filling the queue until it is full, and only then raises full.
// Reset (synchronous, active low) clears the previous energy, sample and
// rollover counts to zero, empties the queue and idles the divider.
module energy_accumulator_average_power #(
    parameter int unsigned QUEUE_DEPTH = eaap_pkg::QDEPTH_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  eaap_pkg::t_reading i_reading,
    output logic               empty,
    input  logic               pop,
    output eaap_pkg::t_result  o_result
);
    import eaap_pkg::*;

    t_job   front_job;
    t_job   queue_job;
    t_qstat queue_stat;
    logic   accept;
    logic   job_take;

    // A reading is accepted exactly when the queue has room for its word.
    assign full   = queue_stat.full;
    assign accept = push && !queue_stat.full;

    // The front end updates its stored previous reading on every accepted word,
    // independent of how far the divider has come.
    eaap_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_reading (i_reading),
        .o_job     (front_job)
    );

    eaap_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (front_job),
        .i_pop   (job_take),
        .o_data  (queue_job),
        .o_stat  (queue_stat)
    );

    // The back end pulls a word whenever it is idle and the queue holds one.
    eaap_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!queue_stat.empty),
        .i_job       (queue_job),
        .o_job_take  (job_take),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (o_result)
    );

`ifndef NO_ASSERTIONS
    // A result flagged for a zero sample difference always carries a zero average.
    a_zero_avg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.zero_samples) |-> (o_result.avg_power == '0))
        else $error("zero sample result with nonzero average");

    // The divider only takes a word that the queue actually holds.
    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_take |-> !queue_stat.empty)
        else $error("divider took a word from an empty queue");

    // The queue can never look both full and empty.
    a_queue_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(queue_stat.full && queue_stat.empty))
        else $error("queue reports full and empty at once");

    // Once the back end takes a word it is busy, so it never takes two in a row.
    a_no_take_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (job_take) |=> !job_take)
        else $error("divider took two words in consecutive cycles");
`endif

endmodule

### rtl/core/eaap_front.sv
module eaap_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  eaap_pkg::t_reading i_reading,
    output eaap_pkg::t_job     o_job
);
    import eaap_pkg::*;

    logic [PLAIN_W-1:0] r_prev_energy;
    logic [SAMP_W-1:0]  r_prev_samples;
    logic [WRAP_W-1:0]  r_prev_wraps;

    logic [PLAIN_W-1:0] plain;
    logic [PLAIN_W-1:0] prev_base;
    logic [WRAP_W-1:0]  missed;
    logic [COMP_W-1:0]  energy;
    logic [SAMP_W-1:0]  sdiff;

    always_comb begin
        // wraps * 32767 is wraps * 32768 - wraps.
        plain = {i_reading.wrap_count, {ACC_W{1'b0}}}
              - PLAIN_W'(i_reading.wrap_count)
              + PLAIN_W'(i_reading.accum_value);
        prev_base = {r_prev_wraps, {ACC_W{1'b0}}}
                  - PLAIN_W'(r_prev_wraps)
                  + PLAIN_W'(i_reading.accum_value);
        // The 8-bit difference already carries the +256 of a wrapped counter.
        missed = i_reading.wrap_count - r_prev_wraps;
        if (i_reading.wrap_count < r_prev_wraps) begin
            energy = COMP_W'(prev_base) + COMP_W'({missed, {ACC_W{1'b0}}});
        end else begin
            energy = COMP_W'(plain);
        end
        // A wrapped sample count falls out of the modulo-2^24 subtraction.
        sdiff = i_reading.samples_total - r_prev_samples;

        o_job.dividend     = AVG_W'(energy) - AVG_W'(r_prev_energy);
        o_job.divisor      = sdiff;
        o_job.energy_now   = ENERGY_W'(plain);
        o_job.zero_samples = (sdiff == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_energy  <= '0;
            r_prev_samples <= '0;
            r_prev_wraps   <= '0;
        end else if (i_accept) begin
            r_prev_energy  <= plain;
            r_prev_samples <= i_reading.samples_total;
            r_prev_wraps   <= i_reading.wrap_count;
        end
    end

endmodule

### rtl/core/eaap_queue.sv
module eaap_queue #(
    parameter int unsigned DEPTH = eaap_pkg::QDEPTH_DEFAULT
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  eaap_pkg::t_job  i_data,
    input  logic            i_pop,
    output eaap_pkg::t_job  o_data,
    output eaap_pkg::t_qstat o_stat
);
    import eaap_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_QW = $clog2(DEPTH + 1);

    t_job              r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_QW-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_stat.full  = (r_count == CNT_QW'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### rtl/core/eaap_back.sv
module eaap_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    input  eaap_pkg::t_job    i_job,
    output logic              o_job_take,
    input  logic              i_pop,
    output logic              o_empty,
    output eaap_pkg::t_result o_result
);
    import eaap_pkg::*;

    t_bstate            r_state, n_state;
    logic [SAMP_W-1:0]  r_rem, n_rem;
    logic [AVG_W-1:0]   r_quo, n_quo;
    logic [SAMP_W-1:0]  r_div, n_div;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    t_result            r_out, n_out;

    logic [SAMP_W+1:0]  trial;
    logic               fits;

    always_comb begin
        // One restoring step: shift in the next dividend bit and try the divisor.
        trial = {1'b0, r_rem, r_quo[AVG_W-1]} - {2'b00, r_div};
        fits  = !trial[SAMP_W+1];

        n_state    = r_state;
        n_rem      = r_rem;
        n_quo      = r_quo;
        n_div      = r_div;
        n_cnt      = r_cnt;
        n_out      = r_out;
        o_job_take = 1'b0;

        unique case (r_state)
            BS_IDLE: begin
                if (i_job_valid) begin
                    o_job_take         = 1'b1;
                    n_out.energy_now   = i_job.energy_now;
                    n_out.zero_samples = i_job.zero_samples;
                    if (i_job.zero_samples) begin
                        n_out.avg_power = '0;
                        n_state         = BS_HOLD;
                    end else begin
                        n_rem   = '0;
                        n_quo   = i_job.dividend;
                        n_div   = i_job.divisor;
                        n_cnt   = CNT_W'(AVG_W - 1);
                        n_state = BS_DIV;
                    end
                end
            end
            BS_DIV: begin
                n_rem = fits ? trial[SAMP_W-1:0] : {r_rem[SAMP_W-2:0], r_quo[AVG_W-1]};
                n_quo = {r_quo[AVG_W-2:0], fits};
                if (r_cnt == '0) begin
                    n_out.avg_power = {r_quo[AVG_W-2:0], fits};
                    n_state         = BS_HOLD;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            BS_HOLD: begin
                if (i_pop) begin
                    n_state = BS_IDLE;
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    assign o_empty  = (r_state != BS_HOLD);
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
        r_cnt <= n_cnt;
        r_out <= n_out;
    end

endmodule

### verif/testbench.sv
module testbench;
    import eaap_pkg::*;

    // Scale of the energy reading: one rollover of the 15-bit accumulator is
    // counted as 32767 units, while a missed rollover is made up with 32768.
    localparam logic [31:0] FULL_SCALE    = 32'd32767;
    localparam logic [31:0] ROLLOVER_STEP = 32'd32768;
    localparam logic [31:0] WRAP_SPAN     = 32'd256;
    localparam logic [31:0] SAMPLE_SPAN   = 32'd16777216;
    localparam int unsigned SAMPLE_MAX    = 24'hFFFFFF;

    // Stimulus sizes. The last stretch of random words runs with no idling.
    localparam int unsigned RANDOM_WORDS = 1630;
    localparam int unsigned CALM_FROM    = 1450;
    localparam int unsigned DRAIN_AT     = 700;

    // Cycles with no word moving on either side before the run is abandoned.
    // A correct block leaves no word moving for at most about a full divide plus
    // a sender gap and a receiver stall between two handshakes.
    localparam int unsigned STUCK_LIMIT = 2000;
    // Cycles to wait after the last expected result for anything stray.
    localparam int unsigned SETTLE_CYCLES = 80;

    logic     i_clk;
    logic     i_rst_n;
    logic     push;
    logic     full;
    t_reading i_reading;
    logic     empty;
    logic     pop;
    t_result  o_result;

    // While set, neither side idles.
    bit calm;

    // Tracks the meter history the block keeps and holds the result words
    // that are owed, oldest first.
    class power_board;
        logic [31:0]       prior_energy;
        logic [SAMP_W-1:0] last_samples;
        logic [WRAP_W-1:0] last_wraps;
        t_result           awaited[$];
        int                failures;

        function new();
            prior_energy = '0;
            last_samples = '0;
            last_wraps   = '0;
            failures     = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // Works out the result of one accepted reading and moves the history on.
        function void note_reading(t_reading r);
            logic [31:0] plain;
            logic [31:0] energy;
            logic [31:0] fresh;
            logic [31:0] span;
            t_result     want;
            plain = 32'(r.wrap_count) * FULL_SCALE + 32'(r.accum_value);
            // A rollover count below the last one means the counter wrapped.
            // The difference then starts from the old count and makes up
            // each missed rollover with a full 32768.
            if (r.wrap_count < last_wraps) begin
                energy = 32'(last_wraps) * FULL_SCALE + 32'(r.accum_value)
                       + (32'(r.wrap_count) + WRAP_SPAN - 32'(last_wraps)) * ROLLOVER_STEP;
            end else begin
                energy = plain;
            end
            // A wrapped sample count is lifted by 2^24 for the difference only.
            fresh = (r.samples_total < last_samples) ? 32'(r.samples_total) + SAMPLE_SPAN
                                                     : 32'(r.samples_total);
            span = fresh - 32'(last_samples);
            want.energy_now   = plain[ENERGY_W-1:0];
            want.zero_samples = (span == 32'd0);
            // The energy difference wraps modulo 2^32 and divides unsigned.
            want.avg_power    = (span == 32'd0) ? '0 : (energy - prior_energy) / span;
            awaited.push_back(want);
            prior_energy = plain;
            last_samples = r.samples_total;
            last_wraps   = r.wrap_count;
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (awaited.size() == 0) begin
                $error("result word with none owed: avg_power %0d energy_now %0d zero_samples %0d",
                       got.avg_power, got.energy_now, got.zero_samples);
                failures++;
                return;
            end
            want = awaited.pop_front();
            if (got.avg_power !== want.avg_power) begin
                $error("avg_power: expected %0d, got %0d", want.avg_power, got.avg_power);
                failures++;
            end
            if (got.energy_now !== want.energy_now) begin
                $error("energy_now: expected %0d, got %0d", want.energy_now, got.energy_now);
                failures++;
            end
            if (got.zero_samples !== want.zero_samples) begin
                $error("zero_samples: expected %0d, got %0d",
                       want.zero_samples, got.zero_samples);
                failures++;
            end
        endfunction
    endclass

    power_board board;

    energy_accumulator_average_power dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_reading (i_reading),
        .empty     (empty),
        .pop       (pop),
        .o_result  (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_reading make_reading(int unsigned acc, int unsigned wraps,
                                              int unsigned samples);
        t_reading r;
        r.accum_value   = ACC_W'(acc);
        r.wrap_count    = WRAP_W'(wraps);
        r.samples_total = SAMP_W'(samples);
        return r;
    endfunction

    // Presents one reading word and holds it until the block takes it. All
    // inputs change only at rising edges, through nonblocking assignments, so
    // the block always sees values that were settled before the edge.
    task automatic send_reading(t_reading r);
        i_reading <= r;
        push      <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (!full) break;
        end
        board.note_reading(r);
    endtask

    // Between words the sender sometimes drops push for a burst of cycles.
    // Push is lowered here only at the step of an acceptance, and raised again
    // only after a later edge, so no step sees two assignments to it.
    task automatic sender_gap();
        if (!calm && $urandom_range(0, 3) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    // The sender stops until every owed result word has come back.
    task automatic wait_drained();
        push <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    // Receiver: pop stays high except for random stall bursts. A word moves at
    // an edge where pop is high and empty is low; the values read right after
    // the edge are the ones the block held going into it.
    initial begin
        pop <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (!calm && $urandom_range(0, 7) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            if (!empty) board.check_result(o_result);
        end
    end

    // Watchdog: a run in which no word moves for too long has hung.
    int unsigned stuck_cycles;
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (push && !full) || (pop && !empty)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    initial begin
        t_reading    plan[$];
        int unsigned meter_acc;
        int unsigned meter_wraps;
        int unsigned meter_samples;
        int unsigned energy_step;
        int unsigned total;
        int unsigned pick;
        t_reading    r;

        board     = new();
        calm      = 1'b0;
        i_rst_n   <= 1'b0;
        push      <= 1'b0;
        i_reading <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words. The first one meets the cleared history, so its
        // sample difference is zero and the flag must come up.
        plan.push_back(make_reading(0, 0, 0));
        plan.push_back(make_reading(32767, 0, 1));
        // Largest energy the fields can express.
        plan.push_back(make_reading(32767, 255, 2));
        plan.push_back(make_reading(0, 255, 3));
        // Rollover counter wrapped from 255 down to 3.
        plan.push_back(make_reading(100, 3, 10));
        // Sample count at its top, then the same count again: zero difference.
        plan.push_back(make_reading(0, 0, SAMPLE_MAX));
        plan.push_back(make_reading(5, 0, SAMPLE_MAX));
        // Sample count wrapped past 2^24.
        plan.push_back(make_reading(10, 1, 4));
        // Energy falls with no counter wrap: the difference goes negative.
        plan.push_back(make_reading(0, 1, 100));
        plan.push_back(make_reading(32767, 255, SAMPLE_MAX));
        // Both counters wrap at once, down to all zeros.
        plan.push_back(make_reading(0, 0, 0));
        plan.push_back(make_reading(1, 255, 1));
        // Counter wrap combined with a zero sample difference.
        plan.push_back(make_reading(32767, 254, 1));
        plan.push_back(make_reading(32767, 128, 24'h800000));
        plan.push_back(make_reading(16384, 255, 24'h800001));
        // A one-step counter wrap with a huge sample jump.
        plan.push_back(make_reading(12345, 0, 24'h7FFFFF));
        plan.push_back(make_reading(21845, 85, 24'h555555));
        plan.push_back(make_reading(10922, 170, 24'hAAAAAA));
        foreach (plan[i]) begin
            send_reading(plan[i]);
            sender_gap();
        end
        wait_drained();

        // Random part. Most words follow a plausible meter: energy and sample
        // count move forward, and both counters wrap now and then. The rest
        // repeat the sample count or are arbitrary readings.
        meter_acc     = 0;
        meter_wraps   = 0;
        meter_samples = 0;
        for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
            if (n == DRAIN_AT) wait_drained();
            if (n == CALM_FROM) calm = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 85) begin
                energy_step = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 300 * 32768)
                                                           : $urandom_range(0, 40000);
                total       = meter_acc + energy_step;
                meter_acc   = total % 32768;
                meter_wraps = (meter_wraps + total / 32768) % 256;
                if (pick < 75) begin
                    meter_samples += ($urandom_range(0, 7) == 0) ? $urandom_range(1, 1 << 22)
                                                                 : $urandom_range(1, 2000);
                    meter_samples &= SAMPLE_MAX;
                end
                r = make_reading(meter_acc, meter_wraps, meter_samples);
            end else begin
                r = make_reading($urandom_range(0, 32767), $urandom_range(0, 255),
                                 $urandom_range(0, SAMPLE_MAX));
                meter_acc     = 32'(r.accum_value);
                meter_wraps   = 32'(r.wrap_count);
                meter_samples = 32'(r.samples_total);
            end
            send_reading(r);
            sender_gap();
        end

        // Let the last words through, then watch for anything left over.
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (board.failures == 0 && board.pending() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/eaap_pkg.sv
rtl/core/eaap_front.sv
rtl/core/eaap_queue.sv
rtl/core/eaap_back.sv
rtl/core/energy_accumulator_average_power.sv
verif/testbench.sv
